[sv/bda_pkg.sv]
// shared types, codes and defaults for the banker's deadlock avoidance unit
`timescale 1ns / 1ps
package bda_pkg;

    localparam int DEF_CUSTOMERS   = 5;
    localparam int DEF_RESOURCES   = 5;
    localparam int DEF_AMOUNT_BITS = 8;

    localparam int OP_W        = 3;
    localparam int CUST_W      = 3;
    localparam int IN_AMOUNT_W = 8;
    localparam int STATUS_W    = 3;
    localparam int IN_LANES    = 5;

    localparam logic [OP_W-1:0] OP_LOAD_AVAIL = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_MAX   = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_ALLOC = 3'd2;
    localparam logic [OP_W-1:0] OP_REQUEST    = 3'd3;
    localparam logic [OP_W-1:0] OP_RELEASE    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVER_NEED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WAIT        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNSAFE      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_CHECK_INIT,
        S_CHECK,
        S_ROLLBACK,
        S_DONE
    } seq_state_t;

endpackage

[sv/bda_req_if.sv]
// request channel: operation, customer and one amount per resource
`timescale 1ns / 1ps
interface bda_req_if;
    import bda_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        operation;
    logic [CUST_W-1:0]      customer;
    logic [IN_AMOUNT_W-1:0] amount_0;
    logic [IN_AMOUNT_W-1:0] amount_1;
    logic [IN_AMOUNT_W-1:0] amount_2;
    logic [IN_AMOUNT_W-1:0] amount_3;
    logic [IN_AMOUNT_W-1:0] amount_4;

    modport source (output valid, operation, customer, amount_0, amount_1, amount_2,
                    amount_3, amount_4, input ready);
    modport sink (input valid, operation, customer, amount_0, amount_1, amount_2,
                  amount_3, amount_4, output ready);
endinterface

[sv/bda_rsp_if.sv]
// response channel: status, safety flag and all-finished flag
`timescale 1ns / 1ps
interface bda_rsp_if;
    import bda_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                safe;
    logic                all_finished;

    modport source (output valid, status, safe, all_finished, input ready);
    modport sink (input valid, status, safe, all_finished, output ready);
endinterface

[sv/bankers_deadlock_avoidance.sv]
// banker's algorithm unit: state tables, request checks and iterative safety scan
// a request is captured in idle, applied, safety-scanned, then registered for response;
//   a request that is rolled back runs the safety scan twice
// one request at a time: the next is taken only back in idle, once the last outcome is loaded; the scan visits
//   one customer row per cycle for CUSTOMERS passes through a shared compare/add unit
// reset: asynchronous, active low; available, allocation and need tables all clear
`timescale 1ns / 1ps
module bankers_deadlock_avoidance #(
    parameter int CUSTOMERS   = bda_pkg::DEF_CUSTOMERS,
    parameter int RESOURCES   = bda_pkg::DEF_RESOURCES,
    parameter int AMOUNT_BITS = bda_pkg::DEF_AMOUNT_BITS
) (
    input  logic clk,
    input  logic rst_n,
    bda_req_if.sink   req,
    bda_rsp_if.source rsp
);
    import bda_pkg::*;

    // row index width, and work width wide enough for available plus every allocation
    localparam int CIW = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
    localparam int AB  = AMOUNT_BITS;
    localparam int WW  = AMOUNT_BITS + $clog2(CUSTOMERS + 1);

    typedef logic [RESOURCES-1:0][AB-1:0] amt_row_t;
    typedef logic [RESOURCES-1:0][WW-1:0] work_row_t;

    // state tables, one row per customer
    amt_row_t avail_reg;
    amt_row_t alloc_reg [CUSTOMERS];
    amt_row_t need_reg  [CUSTOMERS];

    // captured request
    logic [OP_W-1:0]   op_reg;
    logic [CUST_W-1:0] cust_reg;
    amt_row_t          amt_reg;

    // sequencer and safety scan
    seq_state_t          state_reg, state_next;
    logic [CIW-1:0]      row_reg;
    logic [CIW-1:0]      pass_reg;
    logic [CUSTOMERS-1:0] done_reg;
    work_row_t           work_reg;
    logic                zero_reg;
    logic                granted_reg;   // request tentatively granted, may need undo
    logic [STATUS_W-1:0] status_reg;

    // response register
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic                rsp_safe_reg;
    logic                rsp_fin_reg;

    // input amounts, masked to the amount width
    logic [IN_AMOUNT_W-1:0] in_amt [IN_LANES];
    amt_row_t               in_row;
    logic [15:0]            ext16 [RESOURCES];

    always_comb
    begin
        in_amt[0] = req.amount_0;
        in_amt[1] = req.amount_1;
        in_amt[2] = req.amount_2;
        in_amt[3] = req.amount_3;
        in_amt[4] = req.amount_4;
        for (int r = 0; r < RESOURCES; r++)
        begin
            ext16[r]  = 16'(in_amt[r]);
            in_row[r] = ext16[r][AB-1:0];
        end
    end

    // row addressed by the scan or by the captured customer
    logic [7:0]     cust_ext;
    logic [CIW-1:0] cust_idx;
    logic [CIW-1:0] rd_idx;
    logic           cust_ok;
    amt_row_t       alloc_row, need_row;

    assign cust_ext  = 8'(cust_reg);
    assign cust_idx  = cust_ext[CIW-1:0];
    assign cust_ok   = 32'(cust_reg) < CUSTOMERS;
    assign rd_idx    = (state_reg == S_CHECK) ? row_reg : cust_idx;
    assign alloc_row = alloc_reg[rd_idx];
    assign need_row  = need_reg[rd_idx];

    // per-resource checks of the captured vector against the customer's row
    logic        over_need, over_avail, bad_release;
    logic [AB:0] rel_sum [RESOURCES];

    always_comb
    begin
        over_need   = 1'b0;
        over_avail  = 1'b0;
        bad_release = 1'b0;
        for (int r = 0; r < RESOURCES; r++)
        begin
            rel_sum[r] = {1'b0, avail_reg[r]} + {1'b0, amt_reg[r]};
            if (amt_reg[r] > need_row[r])
                over_need = 1'b1;
            if (amt_reg[r] > avail_reg[r])
                over_avail = 1'b1;
            if (amt_reg[r] > alloc_row[r] || rel_sum[r][AB])
                bad_release = 1'b1;
        end
    end

    // shared scan unit: does the row's need fit in work, and work plus allocation
    logic      row_fits;
    logic      row_zero;
    work_row_t work_sum;

    always_comb
    begin
        row_fits = 1'b1;
        row_zero = 1'b1;
        for (int r = 0; r < RESOURCES; r++)
        begin
            if (WW'(need_row[r]) > work_reg[r])
                row_fits = 1'b0;
            if (need_row[r] != '0)
                row_zero = 1'b0;
            work_sum[r] = work_reg[r] + WW'(alloc_row[r]);
        end
    end

    logic scan_last;
    logic rsp_free;
    logic all_done;

    assign scan_last = (row_reg == CIW'(CUSTOMERS - 1)) && (pass_reg == CIW'(CUSTOMERS - 1));
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign all_done  = &done_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                    state_next = S_APPLY;
            end
            S_APPLY:      state_next = S_CHECK_INIT;
            S_CHECK_INIT: state_next = S_CHECK;
            S_CHECK:
            begin
                if (scan_last)
                    state_next = S_DONE;
            end
            S_ROLLBACK:   state_next = S_CHECK_INIT;
            S_DONE:
            begin
                // an unsafe grant is undone and the scan runs again
                if (granted_reg && !all_done)
                    state_next = S_ROLLBACK;
                else if (rsp_free)
                    state_next = S_IDLE;
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // tables and scan datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_reg   <= '0;
            for (int c = 0; c < CUSTOMERS; c++)
            begin
                alloc_reg[c] <= '0;
                need_reg[c]  <= '0;
            end
            granted_reg <= 1'b0;
            done_reg    <= '0;
            row_reg     <= '0;
            pass_reg    <= '0;
            zero_reg    <= 1'b1;
            status_reg  <= ST_OK;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    granted_reg <= 1'b0;
                    status_reg  <= ST_OK;
                end
                S_APPLY:
                begin
                    if (op_reg == OP_LOAD_AVAIL)
                        avail_reg <= amt_reg;
                    else if (cust_ok)
                    begin
                        unique case (op_reg)
                            OP_LOAD_MAX:
                            begin
                                need_reg[cust_idx]  <= amt_reg;
                                alloc_reg[cust_idx] <= '0;
                            end
                            OP_LOAD_ALLOC:
                            begin
                                if (over_need)
                                    status_reg <= ST_OVER_NEED;
                                else
                                    for (int r = 0; r < RESOURCES; r++)
                                    begin
                                        alloc_reg[cust_idx][r] <= alloc_row[r] + amt_reg[r];
                                        need_reg[cust_idx][r]  <= need_row[r] - amt_reg[r];
                                    end
                            end
                            OP_REQUEST:
                            begin
                                if (over_need)
                                    status_reg <= ST_OVER_NEED;
                                else if (over_avail)
                                    status_reg <= ST_WAIT;
                                else
                                begin
                                    granted_reg <= 1'b1;
                                    for (int r = 0; r < RESOURCES; r++)
                                    begin
                                        avail_reg[r]           <= avail_reg[r] - amt_reg[r];
                                        alloc_reg[cust_idx][r] <= alloc_row[r] + amt_reg[r];
                                        need_reg[cust_idx][r]  <= need_row[r] - amt_reg[r];
                                    end
                                end
                            end
                            OP_RELEASE:
                            begin
                                if (bad_release)
                                    status_reg <= ST_BAD_RELEASE;
                                else
                                    for (int r = 0; r < RESOURCES; r++)
                                    begin
                                        alloc_reg[cust_idx][r] <= alloc_row[r] - amt_reg[r];
                                        avail_reg[r]           <= rel_sum[r][AB-1:0];
                                    end
                            end
                            default:
                            begin
                                // query and unused codes change nothing
                            end
                        endcase
                    end
                end
                S_CHECK_INIT:
                begin
                    done_reg <= '0;
                    row_reg  <= '0;
                    pass_reg <= '0;
                    zero_reg <= 1'b1;
                end
                S_CHECK:
                begin
                    if (pass_reg == '0 && !row_zero)
                        zero_reg <= 1'b0;
                    if (!done_reg[row_reg] && row_fits)
                        done_reg[row_reg] <= 1'b1;
                    if (row_reg == CIW'(CUSTOMERS - 1))
                    begin
                        row_reg  <= '0;
                        pass_reg <= CIW'(pass_reg + 1'b1);
                    end
                    else
                        row_reg <= CIW'(row_reg + 1'b1);
                end
                S_ROLLBACK:
                begin
                    granted_reg <= 1'b0;
                    status_reg  <= ST_UNSAFE;
                    for (int r = 0; r < RESOURCES; r++)
                    begin
                        avail_reg[r]           <= avail_reg[r] + amt_reg[r];
                        alloc_reg[cust_idx][r] <= alloc_row[r] - amt_reg[r];
                        need_reg[cust_idx][r]  <= need_row[r] + amt_reg[r];
                    end
                end
                S_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // work vector: starts from available, grows as customers finish
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHECK_INIT)
        begin
            for (int r = 0; r < RESOURCES; r++)
                work_reg[r] <= WW'(avail_reg[r]);
        end
        else if (state_reg == S_CHECK && !done_reg[row_reg] && row_fits)
            work_reg <= work_sum;
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg   <= req.operation;
            cust_reg <= req.customer;
            amt_reg  <= in_row;
        end
    end

    // response register, parts the scan from the consumer
    logic rsp_load;

    assign rsp_load = (state_reg == S_DONE) && !(granted_reg && !all_done) && rsp_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (rsp_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_status_reg <= status_reg;
            rsp_safe_reg   <= all_done;
            rsp_fin_reg    <= zero_reg;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.safe         = rsp_safe_reg;
    assign rsp.all_finished = rsp_fin_reg;

endmodule

[sim/bankers_deadlock_avoidance_tb.sv]
// self-checking testbench for the banker's deadlock avoidance unit
`timescale 1ns / 1ps
module bankers_deadlock_avoidance_tb;
    import bda_pkg::*;

    localparam int NCUST = DEF_CUSTOMERS;
    localparam int NRES  = DEF_RESOURCES;
    localparam int AMAX  = (1 << DEF_AMOUNT_BITS) - 1;
    localparam int RANDOM_REQUESTS = 1600;
    // query has no named code in the package; 5 is the plain query, 6 and 7 alias it
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef logic [IN_AMOUNT_W-1:0] amount_vec_t [NRES];

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [CUST_W-1:0]   cust;
        amount_vec_t         amt;
    } bank_request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                safe;
        logic                all_finished;
    } bank_outcome_t;

    // directed row: request plus optional typed-in outcome
    typedef struct {
        bank_request_t req;
        bit            typed;
        bank_outcome_t outcome;
    } directed_row_t;

    logic clk;
    logic rst_n;

    bda_req_if req_ch();
    bda_rsp_if rsp_ch();

    bankers_deadlock_avoidance dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // predictor copy of the bank state
    int unsigned avail_m [NRES];
    int unsigned alloc_m [NCUST][NRES];
    int unsigned need_m  [NCUST][NRES];

    bank_outcome_t outcome_q[$];
    int unsigned   mismatch_count;
    int unsigned   outcome_count;
    int unsigned   status_seen [8];
    bit            sender_done;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // safety scan over the predictor copy
    function automatic bit bank_is_safe();
        int unsigned work [NRES];
        bit          fin [NCUST];
        bit          fits;
        for (int r = 0; r < NRES; r++) work[r] = avail_m[r];
        for (int c = 0; c < NCUST; c++) fin[c] = 1'b0;
        for (int p = 0; p < NCUST; p++)
            for (int c = 0; c < NCUST; c++)
            begin
                if (fin[c]) continue;
                fits = 1'b1;
                for (int r = 0; r < NRES; r++)
                    if (need_m[c][r] > work[r]) fits = 1'b0;
                if (fits)
                begin
                    for (int r = 0; r < NRES; r++) work[r] += alloc_m[c][r];
                    fin[c] = 1'b1;
                end
            end
        for (int c = 0; c < NCUST; c++)
            if (!fin[c]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit bank_all_done();
        for (int c = 0; c < NCUST; c++)
            for (int r = 0; r < NRES; r++)
                if (need_m[c][r] != 0) return 1'b0;
        return 1'b1;
    endfunction

    // apply one request to the predictor copy and return the outcome
    function automatic bank_outcome_t bank_apply(bank_request_t rq);
        bank_outcome_t o;
        int unsigned   a [NRES];
        int            c;
        bit            over_need, over_avail, bad_rel;
        c = int'(rq.cust);
        o.status = ST_OK;
        over_need = 1'b0; over_avail = 1'b0; bad_rel = 1'b0;
        for (int r = 0; r < NRES; r++) a[r] = rq.amt[r] & AMAX;
        if (rq.op == OP_LOAD_AVAIL)
        begin
            for (int r = 0; r < NRES; r++) avail_m[r] = a[r];
        end
        else if (rq.op >= OP_LOAD_MAX && rq.op <= OP_RELEASE && c < NCUST)
        begin
            for (int r = 0; r < NRES; r++)
            begin
                if (a[r] > need_m[c][r]) over_need = 1'b1;
                if (a[r] > avail_m[r]) over_avail = 1'b1;
                if (a[r] > alloc_m[c][r] || avail_m[r] + a[r] > AMAX) bad_rel = 1'b1;
            end
            case (rq.op)
                OP_LOAD_MAX:
                    for (int r = 0; r < NRES; r++)
                    begin
                        need_m[c][r]  = a[r];
                        alloc_m[c][r] = 0;
                    end
                OP_LOAD_ALLOC:
                    if (over_need) o.status = ST_OVER_NEED;
                    else
                        for (int r = 0; r < NRES; r++)
                        begin
                            alloc_m[c][r] += a[r];
                            need_m[c][r]  -= a[r];
                        end
                OP_REQUEST:
                    if (over_need) o.status = ST_OVER_NEED;
                    else if (over_avail) o.status = ST_WAIT;
                    else
                    begin
                        // tentative whole-vector grant, undone if unsafe
                        for (int r = 0; r < NRES; r++)
                        begin
                            avail_m[r]    -= a[r];
                            alloc_m[c][r] += a[r];
                            need_m[c][r]  -= a[r];
                        end
                        if (!bank_is_safe())
                        begin
                            for (int r = 0; r < NRES; r++)
                            begin
                                avail_m[r]    += a[r];
                                alloc_m[c][r] -= a[r];
                                need_m[c][r]  += a[r];
                            end
                            o.status = ST_UNSAFE;
                        end
                    end
                default:
                    if (bad_rel) o.status = ST_BAD_RELEASE;
                    else
                        for (int r = 0; r < NRES; r++)
                        begin
                            alloc_m[c][r] -= a[r];
                            avail_m[r]    += a[r];
                        end
            endcase
        end
        o.safe = bank_is_safe();
        o.all_finished = bank_all_done();
        return o;
    endfunction

    function automatic bank_request_t make_req(logic [OP_W-1:0] op, int cust,
                                               int a0, int a1, int a2, int a3, int a4);
        bank_request_t rq;
        rq.op = op;
        rq.cust = CUST_W'(cust);
        rq.amt[0] = IN_AMOUNT_W'(a0);
        rq.amt[1] = IN_AMOUNT_W'(a1);
        rq.amt[2] = IN_AMOUNT_W'(a2);
        rq.amt[3] = IN_AMOUNT_W'(a3);
        rq.amt[4] = IN_AMOUNT_W'(a4);
        return rq;
    endfunction

    // send one request: random idle gap, then hold valid until accepted
    task automatic send_request(bank_request_t rq, bit typed, bank_outcome_t typed_o);
        bank_outcome_t o;
        int            gap;
        bit            differs;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= rq.op;
        req_ch.customer  <= rq.cust;
        req_ch.amount_0  <= rq.amt[0];
        req_ch.amount_1  <= rq.amt[1];
        req_ch.amount_2  <= rq.amt[2];
        req_ch.amount_3  <= rq.amt[3];
        req_ch.amount_4  <= rq.amt[4];
        do @(posedge clk); while (!req_ch.ready);
        o = bank_apply(rq);
        differs = (o.status != typed_o.status) || (o.safe != typed_o.safe) ||
                  (o.all_finished != typed_o.all_finished);
        // typed-in rows must agree with the predictor too
        if (typed && differs)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display({"typed outcome disagrees: op %0d cust %0d ",
                          "typed %0d/%0d/%0d pred %0d/%0d/%0d"},
                         rq.op, rq.cust, typed_o.status, typed_o.safe, typed_o.all_finished,
                         o.status, o.safe, o.all_finished);
        end
        outcome_q.push_back(typed ? typed_o : o);
        @(negedge clk);
    endtask

    function automatic bank_outcome_t oc(logic [STATUS_W-1:0] s, int sf, int fin);
        bank_outcome_t o;
        o.status = s; o.safe = sf[0]; o.all_finished = fin[0];
        return o;
    endfunction

    function automatic logic [IN_AMOUNT_W-1:0] rnd_amt(int unsigned lim);
        if (lim == 0) return '0;
        return IN_AMOUNT_W'($urandom_range(0, lim));
    endfunction

    // well-formed random request from the current predictor state
    function automatic bank_request_t random_request();
        bank_request_t rq;
        int unsigned   pick;
        int            c;
        int            k;
        pick = $urandom_range(0, 99);
        c = $urandom_range(0, NCUST - 1);
        rq.cust = CUST_W'(c);
        for (int r = 0; r < NRES; r++) rq.amt[r] = IN_AMOUNT_W'($urandom_range(0, 255));
        if (pick < 4)
        begin
            rq.op = OP_LOAD_AVAIL;
            for (int r = 0; r < NRES; r++) rq.amt[r] = IN_AMOUNT_W'($urandom_range(0, 60));
        end
        else if (pick < 10)
        begin
            rq.op = OP_LOAD_MAX;
            for (int r = 0; r < NRES; r++) rq.amt[r] = IN_AMOUNT_W'($urandom_range(0, 40));
        end
        else if (pick < 16)
        begin
            rq.op = OP_LOAD_ALLOC;
            for (int r = 0; r < NRES; r++) rq.amt[r] = rnd_amt(need_m[c][r]);
        end
        else if (pick < 60)
        begin
            rq.op = OP_REQUEST;
            for (int r = 0; r < NRES; r++)
                rq.amt[r] = rnd_amt(need_m[c][r] < avail_m[r] + 2 ? need_m[c][r]
                                                                 : avail_m[r] + 2);
            if ($urandom_range(0, 9) == 0)
            begin
                k = $urandom_range(0, NRES - 1);
                rq.amt[k] = rq.amt[k] + IN_AMOUNT_W'(1);
            end
        end
        else if (pick < 85)
        begin
            rq.op = OP_RELEASE;
            for (int r = 0; r < NRES; r++) rq.amt[r] = rnd_amt(alloc_m[c][r]);
            if ($urandom_range(0, 9) == 0)
            begin
                k = $urandom_range(0, NRES - 1);
                rq.amt[k] = rq.amt[k] + IN_AMOUNT_W'(1);
            end
        end
        else if (pick < 92)
            rq.op = OP_W'(int'(OP_QUERY) + int'($urandom_range(0, 2)));
        else
        begin
            // noise: any op, any customer code, full-range amounts
            rq.op = OP_W'($urandom_range(0, 7));
            rq.cust = CUST_W'($urandom_range(0, 7));
        end
        return rq;
    endfunction

    // directed stimulus: extremes, every operation and each refusal path
    directed_row_t directed [$];

    task automatic add_row(bank_request_t rq, int typed, bank_outcome_t o);
        directed_row_t d;
        d.req = rq; d.typed = (typed != 0); d.outcome = o;
        directed.push_back(d);
    endtask

    initial
    begin
        bank_outcome_t none;
        none = oc(ST_OK, 1, 1);
        rst_n = 1'b0;
        sender_done = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = '0;
        req_ch.customer = '0;
        req_ch.amount_0 = '0; req_ch.amount_1 = '0; req_ch.amount_2 = '0;
        req_ch.amount_3 = '0; req_ch.amount_4 = '0;
        for (int r = 0; r < NRES; r++) avail_m[r] = 0;
        for (int c = 0; c < NCUST; c++)
            for (int r = 0; r < NRES; r++)
            begin
                alloc_m[c][r] = 0;
                need_m[c][r] = 0;
            end

        // after reset everything is zero: safe and finished
        add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0), 1, oc(ST_OK, 1, 1));
        add_row(make_req(OP_UNUSED_HI, 7, 255, 255, 255, 255, 255), 1, oc(ST_OK, 1, 1));
        // out-of-range customer is ignored
        add_row(make_req(OP_LOAD_MAX, 5, 9, 9, 9, 9, 9), 1, oc(ST_OK, 1, 1));
        add_row(make_req(OP_REQUEST, 7, 1, 1, 1, 1, 1), 1, oc(ST_OK, 1, 1));
        // release with nothing allocated is invalid
        add_row(make_req(OP_RELEASE, 0, 1, 0, 0, 0, 0), 1, oc(ST_BAD_RELEASE, 1, 1));
        add_row(make_req(OP_LOAD_AVAIL, 0, 255, 255, 255, 255, 255), 1, oc(ST_OK, 1, 1));
        add_row(make_req(OP_LOAD_MAX, 4, 255, 255, 255, 255, 255), 1, oc(ST_OK, 1, 0));
        add_row(make_req(OP_LOAD_ALLOC, 4, 255, 0, 0, 0, 0), 0, none);
        add_row(make_req(OP_REQUEST, 4, 0, 255, 255, 255, 255), 0, none);
        // a release within the allocation goes through; one overflowing available is invalid
        add_row(make_req(OP_RELEASE, 4, 0, 1, 0, 0, 0), 0, none);
        add_row(make_req(OP_RELEASE, 4, 0, 255, 255, 255, 255), 0, none);
        add_row(make_req(OP_LOAD_AVAIL, 0, 3, 3, 2, 2, 1), 0, none);
        add_row(make_req(OP_LOAD_MAX, 0, 7, 5, 3, 0, 0), 0, none);
        add_row(make_req(OP_LOAD_MAX, 1, 3, 2, 2, 0, 0), 0, none);
        add_row(make_req(OP_LOAD_MAX, 2, 9, 0, 2, 0, 0), 0, none);
        add_row(make_req(OP_LOAD_ALLOC, 1, 2, 0, 0, 0, 0), 0, none);
        add_row(make_req(OP_LOAD_ALLOC, 2, 9, 9, 9, 9, 9), 0, none);
        add_row(make_req(OP_REQUEST, 0, 8, 0, 0, 0, 0), 0, none);
        add_row(make_req(OP_REQUEST, 1, 1, 3, 0, 0, 0), 0, none);
        add_row(make_req(OP_REQUEST, 0, 3, 3, 2, 0, 0), 0, none);
        add_row(make_req(OP_REQUEST, 1, 1, 2, 2, 0, 0), 0, none);
        add_row(make_req(OP_RELEASE, 1, 3, 2, 2, 0, 0), 0, none);
        add_row(make_req(OP_QUERY, 3, 0, 0, 0, 0, 0), 0, none);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_request(directed[i].req, directed[i].typed, directed[i].outcome);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // hold off now and then until the pipeline drains
            if (n % 400 == 200)
            begin
                req_ch.valid <= 1'b0;
                @(negedge clk);
                while (outcome_q.size() != 0) @(negedge clk);
            end
            send_request(random_request(), 1'b0, none);
        end
        req_ch.valid <= 1'b0;
        sender_done = 1'b1;
    end

    // response side: random backpressure, compare against oldest expectation
    initial
    begin
        bank_outcome_t e;
        int            hold;
        rsp_ch.ready = 1'b0;
        mismatch_count = 0;
        outcome_count = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        forever
        begin
            @(negedge clk);
            hold = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) hold = 0;
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_ch.valid && rst_n));
            outcome_count++;
            status_seen[rsp_ch.status]++;
            if (outcome_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected outcome: status %0d safe %0d finished %0d",
                             rsp_ch.status, rsp_ch.safe, rsp_ch.all_finished);
            end
            else
            begin
                e = outcome_q.pop_front();
                if (rsp_ch.status !== e.status || rsp_ch.safe !== e.safe ||
                    rsp_ch.all_finished !== e.all_finished)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("outcome %0d mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 outcome_count, e.status, e.safe, e.all_finished,
                                 rsp_ch.status, rsp_ch.safe, rsp_ch.all_finished);
                end
            end
        end
    end

    // end of run: drain, settle, report
    initial
    begin
        wait (sender_done);
        while (outcome_q.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
        $display("checked %0d outcomes: ok %0d, over need %0d, wait %0d, rolled back %0d",
                 outcome_count, status_seen[ST_OK], status_seen[ST_OVER_NEED],
                 status_seen[ST_WAIT], status_seen[ST_UNSAFE]);
        $display("invalid releases %0d, mismatches %0d",
                 status_seen[ST_BAD_RELEASE], mismatch_count);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog: ~1650 requests with idle gaps, busy time and stalls on a 4 ns clock, many times over
    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
sv/bda_pkg.sv
sv/bda_req_if.sv
sv/bda_rsp_if.sv
sv/bankers_deadlock_avoidance.sv
sim/bankers_deadlock_avoidance_tb.sv
